FILE: hdl/mcet_pkg.sv
// ----------------------------------------------------------------------------
// mcet_pkg
// Shared constants and types of the multi-channel event timer.
// ----------------------------------------------------------------------------
`default_nettype none

package mcet_pkg;

   localparam int CHANNELS_DEF   = 8;
   localparam int COUNT_BITS_DEF = 32;

   localparam logic [3:0] REQ_TICK       = 4'd0;
   localparam logic [3:0] REQ_POLL       = 4'd1;
   localparam logic [3:0] REQ_START      = 4'd2;
   localparam logic [3:0] REQ_TO_START   = 4'd3;
   localparam logic [3:0] REQ_REP_START  = 4'd4;
   localparam logic [3:0] REQ_STOP       = 4'd5;
   localparam logic [3:0] REQ_CLR_COUNT  = 4'd6;
   localparam logic [3:0] REQ_TO_OFF     = 4'd7;
   localparam logic [3:0] REQ_CLR_TO     = 4'd8;
   localparam logic [3:0] REQ_REP_OFF    = 4'd9;
   localparam logic [3:0] REQ_CLR_REP    = 4'd10;
   localparam logic [3:0] REQ_SEC_ON     = 4'd11;
   localparam logic [3:0] REQ_SEC_OFF    = 4'd12;
   localparam logic [3:0] REQ_READ       = 4'd13;

   localparam logic [2:0] KIND_OK        = 3'd0;
   localparam logic [2:0] KIND_NOTFOUND  = 3'd1;
   localparam logic [2:0] KIND_PRIMARY   = 3'd2;
   localparam logic [2:0] KIND_SECONDARY = 3'd3;
   localparam logic [2:0] KIND_READ      = 3'd4;

   // operation carried along the chain with the item
   typedef struct packed {
      logic        tick;
      logic        poll;
      logic        cmd;
      logic [3:0]  req;
      logic [4:0]  chan;
   } op_type;

   // poll events raised by one cell
   typedef struct packed {
      logic sec_to;
      logic prim;
      logic sec_rep;
      logic sec_once;
   } evt_type;

endpackage

`default_nettype wire

FILE: hdl/mcet_cell.sv
// ----------------------------------------------------------------------------
// mcet_cell
// One timer channel: holds its state and acts on the item as it passes.
// ----------------------------------------------------------------------------
`default_nettype none

module mcet_cell
   import mcet_pkg::*;
#(
   parameter int COUNT_BITS = COUNT_BITS_DEF,
   parameter int IDX_BITS   = 5,
   parameter int INDEX      = 0
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  act,      // item is at this cell
   input  wire logic                  live,     // channel below active count
   input  wire op_type                op,
   input  wire logic [COUNT_BITS-1:0] period,
   input  wire logic [COUNT_BITS-1:0] limit,
   input  wire logic                  repeat_flag,
   input  wire logic                  scan_in,  // poll scan still running
   output      logic                  scan_out,
   output      evt_type               evt,
   output      logic [COUNT_BITS-1:0] count_out
);

   localparam logic [COUNT_BITS-1:0] CMAX = '1;
   localparam logic [COUNT_BITS-1:0] ONE  = COUNT_BITS'(1);

   logic [COUNT_BITS-1:0] tick_count_ff, period_value_ff, timeout_count_ff;
   logic [COUNT_BITS-1:0] timeout_value_ff, repeat_count_ff, repeat_target_ff;
   logic timer_on_ff, periodic_ff, timeout_on_ff, repeat_on_ff, second_on_ff;

   logic                  hit_to, hit_pr, on_after_to, rep_done;
   logic [COUNT_BITS-1:0] rep_inc, to_lim;
   logic                  mine, poll_here;

   assign mine      = act && live && op.cmd && (op.chan == IDX_BITS'(INDEX));
   assign poll_here = act && live && op.poll && scan_in;
   assign hit_to    = timeout_on_ff && (timeout_count_ff >= timeout_value_ff);
   assign on_after_to = timer_on_ff && !hit_to;
   assign hit_pr    = on_after_to && (tick_count_ff >= period_value_ff);
   assign rep_inc   = repeat_count_ff + ONE;
   assign rep_done  = repeat_on_ff && (rep_inc >= repeat_target_ff);
   assign to_lim    = (limit >= period) ? limit :
                      ((period == CMAX) ? CMAX : period + ONE);

   assign scan_out  = scan_in && !(poll_here && hit_pr);
   assign count_out = tick_count_ff;

   always_comb begin
      evt.sec_to   = poll_here && hit_to && second_on_ff;
      evt.prim     = poll_here && hit_pr;
      evt.sec_rep  = poll_here && hit_pr && rep_done && second_on_ff;
      evt.sec_once = poll_here && hit_pr && !periodic_ff && second_on_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff    <= '0;
         period_value_ff  <= '0;
         timeout_count_ff <= '0;
         timeout_value_ff <= '0;
         repeat_count_ff  <= '0;
         repeat_target_ff <= '0;
         timer_on_ff      <= 1'b0;
         periodic_ff      <= 1'b0;
         timeout_on_ff    <= 1'b0;
         repeat_on_ff     <= 1'b0;
         second_on_ff     <= 1'b0;
      end else if (act && live && op.tick) begin
         if (timeout_on_ff) timeout_count_ff <= timeout_count_ff + ONE;
         if (timer_on_ff)   tick_count_ff    <= tick_count_ff + ONE;
      end else if (poll_here) begin
         if (hit_to) begin
            timeout_count_ff <= '0;
            timer_on_ff      <= 1'b0;
         end
         if (hit_pr) begin
            tick_count_ff <= '0;
            if (repeat_on_ff) repeat_count_ff <= rep_inc;
            if (rep_done || !periodic_ff) timer_on_ff <= 1'b0;
         end
      end else if (mine) begin
         case (op.req)
            REQ_START: begin
               period_value_ff <= period;
               tick_count_ff   <= '0;
               periodic_ff     <= repeat_flag;
               timer_on_ff     <= 1'b1;
            end
            REQ_TO_START: begin
               period_value_ff  <= period;
               tick_count_ff    <= '0;
               periodic_ff      <= 1'b1;
               timer_on_ff      <= 1'b1;
               timeout_value_ff <= to_lim;
               timeout_count_ff <= '0;
               timeout_on_ff    <= 1'b1;
            end
            REQ_REP_START: begin
               repeat_target_ff <= limit;
               repeat_count_ff  <= '0;
               repeat_on_ff     <= 1'b1;
               period_value_ff  <= period;
               periodic_ff      <= 1'b1;
               timer_on_ff      <= 1'b1;
            end
            REQ_STOP:      timer_on_ff      <= 1'b0;
            REQ_CLR_COUNT: tick_count_ff    <= '0;
            REQ_TO_OFF:    timeout_on_ff    <= 1'b0;
            REQ_CLR_TO:    timeout_count_ff <= '0;
            REQ_REP_OFF:   repeat_on_ff     <= 1'b0;
            REQ_CLR_REP:   repeat_count_ff  <= '0;
            REQ_SEC_ON:    second_on_ff     <= 1'b1;
            REQ_SEC_OFF:   second_on_ff     <= 1'b0;
            default: ;
         endcase
      end
   end

endmodule

`default_nettype wire

FILE: hdl/multi_channel_event_timer_unit.sv
// ----------------------------------------------------------------------------
// multi_channel_event_timer_unit
// N-channel timer: a chain of channel cells visited by one item at a time.
// ----------------------------------------------------------------------------
//  channel   ports                               handshake
//  request   req_type/channel/period/limit/flag  start, busy
//  result    rsp_kind/channel/count/last         rsp_valid strobe
//  config    csr_wr_en, csr_wr_data              write on enable
//
// A visit pointer walks the cells, one cell per cycle unless a cell's poll
// events are being emitted; a poll stops at the first primary event. Each
// poll event is held in a register so that the final result carries last.
// Reset clears all channel state and the register. The receiver cannot
// stall; busy drops as the final result is presented, so the next item may
// be accepted in that cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module multi_channel_event_timer_unit
   import mcet_pkg::*;
#(
   parameter int CHANNELS   = CHANNELS_DEF,
   parameter int COUNT_BITS = COUNT_BITS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        start,
   output      logic        busy,
   input  wire logic [3:0]  req_type,
   input  wire logic [2:0]  req_channel,
   input  wire logic [31:0] req_period,
   input  wire logic [31:0] req_limit,
   input  wire logic        req_repeat_flag,
   output      logic        rsp_valid,
   output      logic [2:0]  rsp_kind,
   output      logic [2:0]  rsp_event_channel,
   output      logic [31:0] rsp_count_value,
   output      logic        rsp_last,
   input  wire logic        csr_wr_en,
   input  wire logic [3:0]  csr_wr_data
);

   localparam int PB = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
   localparam int NB = $clog2(CHANNELS + 1);
   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_WALK = 2'd1;
   localparam logic [1:0] ST_EMIT = 2'd2;
   localparam logic [1:0] ST_FIN  = 2'd3;

   logic [3:0]            cfg_ff;
   logic [1:0]            state_ff;
   logic [PB-1:0]         ptr_ff;
   op_type                op_ff;
   logic [COUNT_BITS-1:0] per_ff, lim_ff;
   logic                  flag_ff, scan_ff;
   evt_type               ev_ff;
   logic [PB-1:0]         evc_ff;
   logic                  stop_ff;
   logic                  hold_v_ff;
   logic [2:0]            hold_k_ff;
   logic [PB-1:0]         hold_c_ff;
   logic [2:0]            kind_ff;
   logic [31:0]           cnt_ff;
   logic                  notfound_ff;
   logic                  rsp_valid_ff, rsp_last_ff;
   logic [2:0]            rsp_kind_ff, rsp_chan_ff;
   logic [31:0]           rsp_count_ff;

   logic [NB-1:0]         nact;
   logic [CHANNELS-1:0]   scan_o;
   evt_type               evt [CHANNELS];
   logic [COUNT_BITS-1:0] cnt [CHANNELS];
   evt_type               ce, ev_in;
   logic [2:0]            pick_kind;
   logic                  walk_end;
   logic                  rsp_valid_in, rsp_last_in;
   logic [2:0]            rsp_kind_in, rsp_chan_in;
   logic [31:0]           rsp_count_in;

   assign nact = ({28'd0, cfg_ff} > 32'(CHANNELS)) ? NB'(CHANNELS) : NB'(cfg_ff);

   genvar g;
   generate
      for (g = 0; g < CHANNELS; g++) begin : g_cell
         mcet_cell #(.COUNT_BITS(COUNT_BITS), .IDX_BITS(5), .INDEX(g)) u_cell (
            .clock(clock), .reset(reset),
            .act(state_ff == ST_WALK && ptr_ff == PB'(g)),
            .live((NB+1)'(g) < (NB+1)'(nact)),
            .op(op_ff), .period(per_ff), .limit(lim_ff),
            .repeat_flag(flag_ff), .scan_in(scan_ff),
            .scan_out(scan_o[g]), .evt(evt[g]), .count_out(cnt[g]));
      end
   endgenerate

   assign ce       = evt[ptr_ff];
   assign walk_end = (ptr_ff == PB'(CHANNELS - 1)) || !scan_o[ptr_ff];

   // events of one cell leave in order: timeout, primary, repetition, one shot
   always_comb begin
      ev_in     = ev_ff;
      pick_kind = KIND_SECONDARY;
      if (ev_ff.sec_to) begin
         ev_in.sec_to = 1'b0;
      end else if (ev_ff.prim) begin
         ev_in.prim = 1'b0;
         pick_kind  = KIND_PRIMARY;
      end else if (ev_ff.sec_rep) begin
         ev_in.sec_rep = 1'b0;
      end else begin
         ev_in.sec_once = 1'b0;
      end
   end

   always_comb begin
      rsp_valid_in = 1'b0;
      rsp_last_in  = 1'b0;
      rsp_kind_in  = hold_k_ff;
      rsp_chan_in  = 3'(hold_c_ff);
      rsp_count_in = '0;
      if (state_ff == ST_EMIT && hold_v_ff) begin
         rsp_valid_in = 1'b1;
      end else if (state_ff == ST_FIN) begin
         rsp_valid_in = 1'b1;
         rsp_last_in  = 1'b1;
         if (!hold_v_ff) begin
            rsp_kind_in  = notfound_ff ? KIND_NOTFOUND : kind_ff;
            rsp_chan_in  = op_ff.cmd ? op_ff.chan[2:0] : 3'd0;
            rsp_count_in = notfound_ff ? 32'd0 : cnt_ff;
         end
      end
   end

   assign busy              = (state_ff != ST_IDLE);
   assign rsp_valid         = rsp_valid_ff;
   assign rsp_kind          = rsp_kind_ff;
   assign rsp_event_channel = rsp_chan_ff;
   assign rsp_count_value   = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_kind_ff  <= rsp_kind_in;
      rsp_chan_ff  <= rsp_chan_in;
      rsp_count_ff <= rsp_count_in;
      rsp_last_ff  <= rsp_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff    <= '0;
         state_ff  <= ST_IDLE;
         hold_v_ff <= 1'b0;
      end else begin
         if (csr_wr_en) cfg_ff <= csr_wr_data;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  op_ff.tick <= (req_type == REQ_TICK);
                  op_ff.poll <= (req_type == REQ_POLL);
                  op_ff.cmd  <= (req_type != REQ_TICK) && (req_type != REQ_POLL);
                  op_ff.req  <= req_type;
                  op_ff.chan <= 5'(req_channel);
                  per_ff    <= COUNT_BITS'(req_period);
                  lim_ff    <= COUNT_BITS'(req_limit);
                  flag_ff   <= req_repeat_flag;
                  scan_ff   <= 1'b1;
                  ptr_ff    <= '0;
                  hold_v_ff <= 1'b0;
                  kind_ff   <= (req_type == REQ_READ) ? KIND_READ : KIND_OK;
                  cnt_ff    <= '0;
                  notfound_ff <= (req_type >= REQ_START) && (req_type <= REQ_READ) &&
                                 (32'(req_channel) >= 32'(nact));
                  state_ff  <= ST_WALK;
               end
            end
            ST_WALK: begin
               scan_ff <= scan_o[ptr_ff];
               if (op_ff.cmd && op_ff.chan == 5'(ptr_ff) && kind_ff == KIND_READ)
                  cnt_ff <= 32'(cnt[ptr_ff]);
               ev_ff   <= ce;
               evc_ff  <= ptr_ff;
               stop_ff <= walk_end;
               if (ce != '0) state_ff <= ST_EMIT;
               else if (walk_end) state_ff <= ST_FIN;
               else ptr_ff <= ptr_ff + PB'(1);
            end
            ST_EMIT: begin
               hold_v_ff <= 1'b1;
               hold_k_ff <= pick_kind;
               hold_c_ff <= evc_ff;
               ev_ff     <= ev_in;
               if (ev_in == '0) begin
                  if (stop_ff) begin
                     state_ff <= ST_FIN;
                  end else begin
                     ptr_ff   <= ptr_ff + PB'(1);
                     state_ff <= ST_WALK;
                  end
               end
            end
            ST_FIN: state_ff <= ST_IDLE;
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule

`default_nettype wire
